>>> hdl/ptb_pkg.sv
// Shared types and defaults for the palindromic tree builder.
// Depends on nothing; used by palindromic_tree_builder.
package ptb_pkg;

	localparam int MAX_LEN_DEF  = 1024;
	localparam int ALPHABET_DEF = 26;
	localparam int RES_W        = 11;

	typedef struct packed {
		logic [4:0] symbol;
		logic       restart;
	} item_t;

	typedef struct packed {
		logic [RES_W-1:0] suffix_palindromes;
		logic [RES_W-1:0] longest_suffix_len;
		logic             full_res;
	} result_t;

endpackage

>>> hdl/palindromic_tree_builder.sv
// Palindromic tree (eertree) builder: one letter in, one result out. Depends on ptb_pkg.
// A dropped letter (text full) goes straight to the output; else a walk finds x, and its
// child is reported if it exists, else a second walk finds y and a node is made. A walk
// passes S_WLEN, S_WCHK, S_WCMP per node compared, S_WLEN, S_WCHK per node too long to
// mirror, S_WLEN for the odd root. Ready again in the cycle after the result loads.
// Reset: arst_n clears control state; child entries are trusted only through a node key.
module palindromic_tree_builder #(
	parameter int MAX_LEN  = ptb_pkg::MAX_LEN_DEF,
	parameter int ALPHABET = ptb_pkg::ALPHABET_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  ptb_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output ptb_pkg::result_t result
);

	localparam int NODE_CAP = MAX_LEN + 2;
	localparam int NW       = $clog2(NODE_CAP);
	localparam int LW       = $clog2(MAX_LEN + 1);
	localparam int CW       = $clog2(ALPHABET);
	localparam int SLOTS    = NODE_CAP * ALPHABET;
	localparam int SW       = $clog2(SLOTS);
	localparam int RW       = ptb_pkg::RES_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WLEN = 4'd1;
	localparam logic [3:0] S_WCHK = 4'd2;
	localparam logic [3:0] S_WCMP = 4'd3;
	localparam logic [3:0] S_CRD  = 4'd4;
	localparam logic [3:0] S_CCHK = 4'd5;
	localparam logic [3:0] S_CVAL = 4'd6;
	localparam logic [3:0] S_MAKE = 4'd7;
	localparam logic [3:0] S_ORD  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	// Fold a 5-bit symbol into the alphabet (constant table)
	function automatic logic [CW-1:0] fold(input logic [4:0] s);
		logic [CW-1:0] r;
		r = '0;
		for (int v = 0; v < 32; v++) begin
			if (s == 5'(v)) r = CW'(v % ALPHABET);
		end
		return r;
	endfunction

	function automatic logic [RW-1:0] fit(input logic [LW-1:0] v);
		logic [LW+RW-1:0] w;
		w = {{RW{1'b0}}, v};
		return w[RW-1:0];
	endfunction

	// Memories
	logic [CW-1:0] letters_mem [MAX_LEN+1];
	logic [LW-1:0] len_mem     [NODE_CAP];
	logic [NW-1:0] link_mem    [NODE_CAP];
	logic [LW-1:0] cnt_mem     [NODE_CAP];
	logic [SW-1:0] key_mem     [NODE_CAP];
	logic [NW-1:0] child_mem   [SLOTS];

	logic [CW-1:0] letter_rd;
	logic [LW-1:0] len_rd, cnt_rd;
	logic [NW-1:0] link_rd, child_rd;
	logic [SW-1:0] key_rd;

	// Control and working registers
	logic [3:0]    state_q;
	logic [LW-1:0] pos_q;
	logic [NW-1:0] last_q, total_q, n_q, lnk_q, xlink_q, cand_q, link_q;
	logic [CW-1:0] c_q;
	logic [LW-1:0] lenw_q, newlen_q;
	logic [SW-1:0] slot_q, xslot_q;
	logic          second_q, candok_q;
	logic          res_full_q;
	logic [LW-1:0] res_cnt_q, res_len_q;
	logic          ovalid_q;
	ptb_pkg::result_t out_q;

	// Combinational helpers
	logic          accept;
	logic [LW-1:0] pos_eff;
	logic [LW-1:0] len_w;
	logic [NW-1:0] lnk_w;
	logic          too_short;
	logic [LW-1:0] mir_idx;
	logic          hit;
	logic [NW-1:0] new_node;
	logic [LW-1:0] cnt_link;
	logic [SW-1:0] n_slot;
	logic          walk_done;
	logic          letter_eq;

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign pos_eff      = item.restart ? '0 : pos_q;
	assign len_w        = (n_q == '0) ? '0 : len_rd;
	assign lnk_w        = (n_q == '0) ? NW'(1) : link_rd;
	assign too_short    = ({1'b0, len_w} + (LW+1)'(1)) >= {1'b0, pos_q};
	assign mir_idx      = pos_q - len_w - LW'(1);
	assign hit          = candok_q && (key_rd == slot_q);
	assign new_node     = total_q + NW'(1);
	assign cnt_link     = (link_q < NW'(2)) ? '0 : cnt_rd;
	assign n_slot       = SW'(n_q) * SW'(ALPHABET) + SW'(c_q);
	assign letter_eq    = (letter_rd == c_q);
	assign walk_done    = ((state_q == S_WLEN) && (n_q == NW'(1)))
	                   || ((state_q == S_WCMP) && letter_eq);

	// Letter store: write on transfer unless the text is full, read at the mirrored position
	always_ff @(posedge clk) begin
		if (accept && (pos_eff < LW'(MAX_LEN))) letters_mem[pos_eff + LW'(1)] <= fold(item.symbol);
		letter_rd <= letters_mem[mir_idx];
	end

	// Node stores: written when a node is made
	always_ff @(posedge clk) begin
		if (state_q == S_MAKE) begin
			len_mem[new_node]  <= newlen_q;
			link_mem[new_node] <= link_q;
			cnt_mem[new_node]  <= cnt_link + LW'(1);
			key_mem[new_node]  <= xslot_q;
		end
		len_rd  <= len_mem[(state_q == S_CVAL) ? cand_q : n_q];
		link_rd <= link_mem[n_q];
		cnt_rd  <= cnt_mem[cand_q];
		key_rd  <= key_mem[child_rd];
	end

	// Child table: entries trusted only if the node's key points back
	always_ff @(posedge clk) begin
		if (state_q == S_MAKE) child_mem[xslot_q] <= new_node;
		child_rd <= child_mem[slot_q];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pos_q      <= '0;
			last_q     <= '0;
			total_q    <= NW'(1);
			second_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						c_q <= fold(item.symbol);
						if (item.restart) begin
							last_q  <= '0;
							total_q <= NW'(1);
						end
						if (pos_eff >= LW'(MAX_LEN)) begin
							pos_q      <= pos_eff;
							res_full_q <= 1'b1;
							res_cnt_q  <= '0;
							res_len_q  <= '0;
							state_q    <= S_OUT;
						end else begin
							pos_q      <= pos_eff + LW'(1);
							n_q        <= item.restart ? '0 : last_q;
							second_q   <= 1'b0;
							res_full_q <= 1'b0;
							state_q    <= S_WLEN;
						end
					end
				end
				S_WLEN: begin
					if (n_q != NW'(1)) state_q <= S_WCHK;
				end
				S_WCHK: begin
					lenw_q <= len_w;
					lnk_q  <= lnk_w;
					if (too_short) begin
						n_q     <= lnk_w;
						state_q <= S_WLEN;
					end else begin
						state_q <= S_WCMP;
					end
				end
				S_WCMP: begin
					if (!letter_eq) begin
						n_q     <= lnk_q;
						state_q <= S_WLEN;
					end
				end
				S_CRD: state_q <= S_CCHK;
				S_CCHK: begin
					cand_q   <= child_rd;
					candok_q <= (child_rd >= NW'(2)) && (child_rd <= total_q);
					state_q  <= S_CVAL;
				end
				S_CVAL: begin
					if (!second_q) begin
						if (hit) begin
							last_q  <= cand_q;
							state_q <= S_ORD;
						end else if (NW'(32'(total_q) + 1 < NODE_CAP ? 1 : 0) != '0) begin
							xslot_q  <= slot_q;
							second_q <= 1'b1;
							n_q      <= xlink_q;
							state_q  <= S_WLEN;
						end else begin
							last_q    <= '0;
							res_cnt_q <= '0;
							res_len_q <= '0;
							state_q   <= S_OUT;
						end
					end else begin
						link_q  <= hit ? cand_q : '0;
						state_q <= S_MAKE;
					end
				end
				S_MAKE: begin
					total_q   <= new_node;
					last_q    <= new_node;
					res_cnt_q <= cnt_link + LW'(1);
					res_len_q <= newlen_q;
					state_q   <= S_OUT;
				end
				S_ORD: begin
					res_cnt_q <= cnt_rd;
					res_len_q <= len_rd;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (!ovalid_q || result_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// Finish a walk: remember x or y and form the child slot
			if (walk_done) begin
				slot_q  <= n_slot;
				state_q <= S_CRD;
				if (!second_q) begin
					xlink_q  <= (n_q == NW'(1)) ? '0 : lnk_q;
					newlen_q <= (n_q == NW'(1)) ? LW'(1) : lenw_q + LW'(2);
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if ((state_q == S_OUT) && (!ovalid_q || result_ready)) begin
			ovalid_q <= 1'b1;
		end else if (result_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && (!ovalid_q || result_ready)) begin
			out_q.suffix_palindromes <= fit(res_cnt_q);
			out_q.longest_suffix_len <= fit(res_len_q);
			out_q.full_res           <= res_full_q;
		end
	end

	assign result_valid = ovalid_q;
	assign result       = out_q;

endmodule
